[rtl/hud_pkg.sv]
// Package with the shared types and constants of the hex up/down display block.
package hud_pkg;

    // Width of the configuration register and of the displayed count.
    localparam int unsigned THR_WIDTH   = 16;
    localparam int unsigned COUNT_BITS  = 8;
    localparam int unsigned SEG_BITS    = 7;
    localparam int unsigned EN_BITS     = 2;

    // Press threshold after reset.
    localparam logic [THR_WIDTH-1:0] THR_RESET = 16'd20000;

    // All segments dark (the segment lines are active low).
    localparam logic [SEG_BITS-1:0] SEG_OFF = 7'h7F;

    // Digit drive codes.
    localparam logic [EN_BITS-1:0] DIG_NONE = 2'b00;
    localparam logic [EN_BITS-1:0] DIG_HIGH = 2'b01;
    localparam logic [EN_BITS-1:0] DIG_LOW  = 2'b10;

    // Active-high segment patterns a-g in bits 0-6, one per hex digit.
    localparam logic [SEG_BITS-1:0] SEG_TABLE [16] = '{
        7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h27,
        7'h7F, 7'h6F, 7'h77, 7'h7C, 7'h58, 7'h5E, 7'h79, 7'h71
    };

    // Control that the top level hands to the display driver.
    typedef struct packed {
        logic advance;
        logic tick;
    } hud_disp_ctrl_t;

endpackage

[rtl/hud_if.sv]
// Channel interfaces of the hex up/down display block: samples, results, configuration.
interface hud_in_if;
    logic valid;
    logic ready;
    logic button_up_level;
    logic button_down_level;
    logic refresh_tick;

    modport source (output valid, output button_up_level, output button_down_level,
                    output refresh_tick, input ready);
    modport sink   (input valid, input button_up_level, input button_down_level,
                    input refresh_tick, output ready);
endinterface

interface hud_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] segments_n;
    logic [1:0] digit_enable;
    logic [7:0] count_value;

    modport source (output valid, output segments_n, output digit_enable,
                    output count_value, input ready);
    modport sink   (input valid, input segments_n, input digit_enable,
                    input count_value, output ready);
endinterface

interface hud_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] press_threshold;

    modport source (output valid, output press_threshold, input ready);
    modport sink   (input valid, input press_threshold, output ready);
endinterface

[rtl/hud_button.sv]
// Press counter and latch of one button, with its step decision.
module hud_button
    import hud_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 level,
    input  logic [THR_WIDTH-1:0] threshold,
    output logic                 fire
);

    localparam int unsigned CMP_W = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] cnt_reg, cnt_next, cnt_inc;
    logic                   latch_reg, latch_next, latch_mid;
    logic [CMP_W-1:0]       cnt_cmp, thr_cmp;

    always_comb
    begin
        cnt_inc   = cnt_reg;
        latch_mid = latch_reg;
        if (level)
        begin
            if (!latch_reg && (cnt_reg != CNT_MAX))
            begin
                cnt_inc = cnt_reg + 1'b1;
            end
        end
        else
        begin
            latch_mid = 1'b0;
        end
        cnt_cmp = CMP_W'(cnt_inc);
        thr_cmp = CMP_W'(threshold);
        fire    = cnt_cmp > thr_cmp;
        if (fire)
        begin
            cnt_next   = '0;
            latch_next = 1'b1;
        end
        else
        begin
            cnt_next   = cnt_inc;
            latch_next = latch_mid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            latch_reg <= 1'b0;
        end
        else if (advance)
        begin
            cnt_reg   <= cnt_next;
            latch_reg <= latch_next;
        end
    end

endmodule

[rtl/hud_display.sv]
// Digit multiplexer that drives one seven-segment digit per refresh tick.
module hud_display
    import hud_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  hud_disp_ctrl_t        ctrl,
    input  logic [COUNT_BITS-1:0] count,
    output logic [SEG_BITS-1:0]   segments_n,
    output logic [EN_BITS-1:0]    digit_enable
);

    logic                sel_reg, sel_next;
    logic [SEG_BITS-1:0] seg_reg, seg_next;
    logic [EN_BITS-1:0]  en_reg, en_next;
    logic [3:0]          nibble;

    always_comb
    begin
        nibble   = sel_reg ? count[3:0] : count[7:4];
        sel_next = sel_reg;
        seg_next = seg_reg;
        en_next  = en_reg;
        if (ctrl.tick)
        begin
            seg_next = ~SEG_TABLE[nibble];
            en_next  = sel_reg ? DIG_LOW : DIG_HIGH;
            sel_next = ~sel_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 1'b0;
            seg_reg <= SEG_OFF;
            en_reg  <= DIG_NONE;
        end
        else if (ctrl.advance)
        begin
            sel_reg <= sel_next;
            seg_reg <= seg_next;
            en_reg  <= en_next;
        end
    end

    assign segments_n   = seg_reg;
    assign digit_enable = en_reg;

endmodule

[rtl/hex_updown_display_mux_core.sv]
// Top level of the two-digit hex up/down counter with multiplexed display.
//
//   channel   direction  handshake      payload
//   samples   in         valid/ready    button_up_level, button_down_level, refresh_tick
//   display   out        valid/ready    segments_n, digit_enable, count_value
//   cfg       in         valid/ready    press_threshold (always ready)
//
// A request passes from acceptance to result through the sample register, then
// through the button counters, count step and digit lookup into the state registers,
// which also serve as the result register. One request is accepted per cycle while
// the display side takes results. Reset clears all counters and latches, blanks the
// segments and restores the threshold to 20000. A stall on the display side holds the
// result and the state; the sample register still takes one more request before the
// sample side stalls too.
module hex_updown_display_mux_core
    import hud_pkg::*;
#(
    parameter int unsigned COUNT_WIDTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    hud_in_if.sink    samples,
    hud_out_if.source display,
    hud_cfg_if.sink   cfg
);

    // Configuration register; the user must write it only while the block is idle, the block does not enforce this.
    logic [THR_WIDTH-1:0] thr_reg;

    // Sample register between the input channel and the update logic.
    logic s1_valid_reg;
    logic s1_up_reg;
    logic s1_down_reg;
    logic s1_tick_reg;

    // The result stage is free when it is empty or its result leaves this cycle.
    logic out_valid_reg;
    logic advance;
    logic in_fire;

    logic fire_up;
    logic fire_down;

    logic [COUNT_BITS-1:0] count_reg, count_next;

    hud_disp_ctrl_t disp_ctrl;

    assign advance = s1_valid_reg && (!out_valid_reg || display.ready);
    assign samples.ready = !s1_valid_reg || advance;
    assign in_fire = samples.valid && samples.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg.valid)
        begin
            thr_reg <= cfg.press_threshold;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (samples.ready)
        begin
            s1_valid_reg <= samples.valid;
        end
    end

    // Payload of the sample register needs no reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_up_reg   <= samples.button_up_level;
            s1_down_reg <= samples.button_down_level;
            s1_tick_reg <= samples.refresh_tick;
        end
    end

    // Each button keeps its own press counter and latch.
    hud_button #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_btn_up (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .level     (s1_up_reg),
        .threshold (thr_reg),
        .fire      (fire_up)
    );

    hud_button #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_btn_down (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .level     (s1_down_reg),
        .threshold (thr_reg),
        .fire      (fire_down)
    );

    // Both steps in one sample cancel; the count wraps in both directions.
    always_comb
    begin
        count_next = count_reg;
        if (fire_up && !fire_down)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (fire_down && !fire_up)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                count_reg <= count_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (display.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The refresh tick shows a digit of the count after this sample's step.
    assign disp_ctrl.advance = advance;
    assign disp_ctrl.tick    = s1_tick_reg;

    hud_display u_display (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (disp_ctrl),
        .count        (count_next),
        .segments_n   (display.segments_n),
        .digit_enable (display.digit_enable)
    );

    assign display.valid       = out_valid_reg;
    assign display.count_value = count_reg;

`ifndef SYNTHESIS
    // A waiting sample is never dropped while the result side is stalled.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("sample lost while result side stalled");

    // The count only moves when a sample is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(count_reg))
        else $error("count changed without a processed sample");

    // At most one digit is driven at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(display.digit_enable))
        else $error("more than one digit driven");

    // After a processed refresh tick some digit is driven.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_tick_reg) |=> (display.digit_enable != DIG_NONE))
        else $error("refresh tick left the display dark");

    // A processed sample always yields a result on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("processed sample produced no result");
`endif

endmodule

[sim/hex_updown_display_mux_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the hex up/down counter with multiplexed seven-segment display.
module hex_updown_display_mux_core_test;
    import hud_pkg::*;

    // The press counters are built at this width; the prediction saturates at the same top.
    localparam int unsigned PRESS_CNT_W  = 16;
    localparam int unsigned PHASES       = 8;
    localparam int unsigned PHASE_ITEMS  = 200;
    // Holding a button this long at the largest threshold leaves a count well above small ones.
    localparam int unsigned HOLD_LEN     = 64;
    localparam int unsigned LONG_STALL   = 300;
    // Wait after the last result is back, allowed for the block to settle.
    localparam int unsigned SETTLE       = 6;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam logic [THR_WIDTH-1:0] THR_MAX = '1;

    // How much a side idles between requests in a phase.
    typedef enum int unsigned {IDLE_NONE, IDLE_RARE, IDLE_FULL} idle_mode_t;

    typedef struct packed {
        logic up;
        logic down;
        logic tick;
    } sample_t;

    typedef struct packed {
        logic [SEG_BITS-1:0]   seg_n;
        logic [EN_BITS-1:0]    dig_en;
        logic [COUNT_BITS-1:0] value;
    } display_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hud_in_if  in_ch ();
    hud_out_if out_ch ();
    hud_cfg_if cfg_ch ();

    hex_updown_display_mux_core #(
        .COUNT_WIDTH (PRESS_CNT_W)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_ch),
        .display (out_ch),
        .cfg     (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Requests waiting to be offered, and the display states they must produce, in order.
    sample_t  pending_samples [$];
    display_t expected_display [$];

    // Mirror of the block's state, kept in step with every accepted request.
    logic [THR_WIDTH-1:0]   press_threshold_q = THR_RESET;
    logic [PRESS_CNT_W-1:0] press_cnt [2]     = '{'0, '0};
    logic                   press_latch [2]   = '{1'b0, 1'b0};
    logic [COUNT_BITS-1:0]  shown_count       = '0;
    logic                   next_is_low       = 1'b0;
    logic [SEG_BITS-1:0]    seg_q             = SEG_OFF;
    logic [EN_BITS-1:0]     dig_en_q          = DIG_NONE;

    // Handshake flags passed from the rising-edge monitor to the falling-edge drivers.
    logic        sample_taken = 1'b0;
    logic        result_taken = 1'b0;
    logic        recv_block   = 1'b0;
    idle_mode_t  send_idle    = IDLE_NONE;
    idle_mode_t  recv_idle    = IDLE_NONE;
    int unsigned send_wait    = 0;
    int unsigned recv_wait    = 0;

    int unsigned cycle_count     = 0;
    int unsigned error_count     = 0;
    int unsigned samples_sent    = 0;
    int unsigned results_checked = 0;
    int unsigned steps_up        = 0;
    int unsigned steps_down      = 0;
    int unsigned input_stalls    = 0;
    int unsigned settings_used   = 0;

    // Number of cycles a side waits before its next request.
    function automatic int unsigned draw_wait(idle_mode_t mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 19);
            default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
        endcase
    endfunction

    // One button for one sample. The counter grows while the button is held and its latch is
    // open, and saturates at its top. Release opens the latch but leaves the counter alone. The
    // threshold test is made whether or not the button is held, so a counter left above a newly
    // lowered threshold fires on the next sample even with the button released.
    function automatic logic press_advance(int unsigned idx, logic level);
        if (level)
        begin
            if (!press_latch[idx] && press_cnt[idx] != '1)
                press_cnt[idx] = press_cnt[idx] + 1'b1;
        end
        else
            press_latch[idx] = 1'b0;
        if (press_cnt[idx] > PRESS_CNT_W'(press_threshold_q))
        begin
            press_latch[idx] = 1'b1;
            press_cnt[idx]   = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Display state after one accepted sample. When both buttons fire together the count
    // goes up and then down, ending where it was. The refresh tick shows the updated count.
    function automatic display_t next_display(sample_t s);
        logic     up_fire;
        logic     down_fire;
        logic [3:0] nibble;
        display_t r;
        up_fire   = press_advance(0, s.up);
        down_fire = press_advance(1, s.down);
        if (up_fire)
        begin
            shown_count = shown_count + 1'b1;
            steps_up++;
        end
        if (down_fire)
        begin
            shown_count = shown_count - 1'b1;
            steps_down++;
        end
        if (s.tick)
        begin
            nibble      = next_is_low ? shown_count[3:0] : shown_count[7:4];
            seg_q       = ~SEG_TABLE[nibble];
            dig_en_q    = next_is_low ? DIG_LOW : DIG_HIGH;
            next_is_low = ~next_is_low;
        end
        r.seg_n  = seg_q;
        r.dig_en = dig_en_q;
        r.value  = shown_count;
        return r;
    endfunction

    // Sample driver. A request stays offered until the monitor reports it taken, then the
    // drawn wait runs out before the next one goes up. With no wait, valid simply stays high.
    always @(negedge clk)
    begin : drive_requests
        sample_t next_req;
        logic    offer;
        if (rst_n)
        begin
            offer = in_ch.valid;
            if (sample_taken)
            begin
                sample_taken = 1'b0;
                offer        = 1'b0;
            end
            if (!offer)
            begin
                if (send_wait > 0)
                    send_wait--;
                else if (pending_samples.size() > 0)
                begin
                    next_req = pending_samples.pop_front();
                    in_ch.button_up_level   <= next_req.up;
                    in_ch.button_down_level <= next_req.down;
                    in_ch.refresh_tick      <= next_req.tick;
                    offer     = 1'b1;
                    send_wait = draw_wait(send_idle);
                end
            end
            in_ch.valid <= offer;
        end
    end

    // Display-side ready. Each taken result draws a wait; recv_block holds results back
    // for a long stretch so the block fills up and stalls its sample input.
    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (result_taken)
            begin
                result_taken = 1'b0;
                recv_wait    = draw_wait(recv_idle);
            end
            if (recv_wait > 0)
            begin
                recv_wait--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= !recv_block;
        end
    end

    // Monitor. Results are checked before the request of the same edge is predicted; a
    // correct block never returns a result in the cycle its request is taken.
    always @(posedge clk)
    begin : watch_channels
        display_t want;
        sample_t  got_req;
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                result_taken = 1'b1;
                if (expected_display.size() == 0)
                begin
                    $error("display result with no request outstanding: seg %h en %h count %h",
                           out_ch.segments_n, out_ch.digit_enable, out_ch.count_value);
                    error_count++;
                end
                else
                begin
                    want = expected_display.pop_front();
                    results_checked++;
                    if (out_ch.segments_n !== want.seg_n)
                    begin
                        $error("segments_n: expected %h, got %h", want.seg_n, out_ch.segments_n);
                        error_count++;
                    end
                    if (out_ch.digit_enable !== want.dig_en)
                    begin
                        $error("digit_enable: expected %h, got %h",
                               want.dig_en, out_ch.digit_enable);
                        error_count++;
                    end
                    if (out_ch.count_value !== want.value)
                    begin
                        $error("count_value: expected %h, got %h",
                               want.value, out_ch.count_value);
                        error_count++;
                    end
                end
            end
            if (in_ch.valid && !in_ch.ready)
                input_stalls++;
            if (in_ch.valid && in_ch.ready)
            begin
                sample_taken   = 1'b1;
                got_req.up     = in_ch.button_up_level;
                got_req.down   = in_ch.button_down_level;
                got_req.tick   = in_ch.refresh_tick;
                samples_sent++;
                expected_display.push_back(next_display(got_req));
            end
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("hex_updown_display_mux_core_test: done, errors");
        $finish;
    end

    task automatic add_sample(input logic up, input logic down, input logic tick);
        sample_t s;
        s.up   = up;
        s.down = down;
        s.tick = tick;
        pending_samples.push_back(s);
    endtask

    // Wait until every request is taken and every result has come back.
    task automatic wait_for_drain();
        while (pending_samples.size() != 0 || in_ch.valid || expected_display.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Threshold writes happen only with the block drained, so no request sees a half-written
    // setting and the mirror can follow right after the handshake.
    task automatic write_threshold(input logic [THR_WIDTH-1:0] value);
        @(negedge clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.press_threshold <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        press_threshold_q = value;
        settings_used++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random phase. Mostly whole presses (hold, then release) with random ticks, sized to the
    // current threshold so steps happen often; the rest is random noise on all three lines.
    task automatic queue_random_phase(input int unsigned n_items);
        int unsigned made;
        int unsigned hold_len;
        int unsigned gap_len;
        int unsigned hold_cap;
        int unsigned pick;
        int unsigned i;
        logic        up_on;
        logic        down_on;
        made     = 0;
        hold_cap = (press_threshold_q < 30) ? 2 * press_threshold_q + 3 : 64;
        while (made < n_items)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                pick     = $urandom_range(0, 9);
                up_on    = (pick < 5) || (pick == 9);
                down_on  = (pick >= 5);
                hold_len = $urandom_range(1, hold_cap);
                gap_len  = $urandom_range(1, 4);
                for (i = 0; i < hold_len; i++)
                    add_sample(up_on, down_on, 1'($urandom_range(0, 1)));
                for (i = 0; i < gap_len; i++)
                    add_sample(1'b0, 1'b0, 1'($urandom_range(0, 1)));
                made += hold_len + gap_len;
            end
            else
            begin
                gap_len = $urandom_range(1, 6);
                for (i = 0; i < gap_len; i++)
                    add_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               1'($urandom_range(0, 1)));
                made += gap_len;
            end
        end
    endtask

    initial
    begin : stimulus
        int unsigned phase_thr [PHASES];
        int unsigned p;
        int unsigned i;
        phase_thr               = '{2, 5, 1, 3, 0, 9, 2, 25};
        in_ch.valid             = 1'b0;
        in_ch.button_up_level   = 1'b0;
        in_ch.button_down_level = 1'b0;
        in_ch.refresh_tick      = 1'b0;
        out_ch.ready            = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.press_threshold  = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset threshold: every combination of the three lines, the first with no tick so
        // the dark display and the empty digit drive show up. No step can happen yet.
        add_sample(1'b0, 1'b0, 1'b0);
        add_sample(1'b1, 1'b0, 1'b1);
        add_sample(1'b0, 1'b1, 1'b0);
        add_sample(1'b1, 1'b1, 1'b1);
        add_sample(1'b0, 1'b0, 1'b1);
        add_sample(1'b1, 1'b0, 1'b0);
        add_sample(1'b0, 1'b1, 1'b1);
        add_sample(1'b1, 1'b1, 1'b0);
        wait_for_drain();

        // Lowest threshold. Both counters already sit above it, so the first release fires
        // both at once and the count stays put. Then a down step wraps below zero, an up press
        // split by a release (the counter survives it) wraps back to zero, and a double press
        // steps both ways in one sample.
        write_threshold(THR_WIDTH'(1));
        add_sample(1'b0, 1'b0, 1'b1);
        add_sample(1'b0, 1'b0, 1'b1);
        add_sample(1'b0, 1'b1, 1'b1);
        add_sample(1'b0, 1'b1, 1'b0);
        add_sample(1'b0, 1'b1, 1'b1);
        add_sample(1'b0, 1'b0, 1'b1);
        add_sample(1'b1, 1'b0, 1'b0);
        add_sample(1'b0, 1'b0, 1'b1);
        add_sample(1'b1, 1'b0, 1'b1);
        add_sample(1'b0, 1'b0, 1'b0);
        add_sample(1'b1, 1'b1, 1'b1);
        add_sample(1'b1, 1'b1, 1'b1);
        add_sample(1'b1, 1'b1, 1'b0);
        add_sample(1'b0, 1'b0, 1'b1);
        wait_for_drain();

        // Largest threshold: holding the up button builds up its counter and no step is
        // taken. Lowering the threshold afterwards lets the built-up counter fire on a
        // released sample.
        write_threshold(THR_MAX);
        for (i = 0; i < HOLD_LEN; i++)
            add_sample(1'b1, 1'b0, 1'($urandom_range(0, 1)));
        wait_for_drain();
        write_threshold(THR_WIDTH'(3));
        add_sample(1'b0, 1'b0, 1'b1);
        add_sample(1'b0, 1'b0, 1'b1);
        wait_for_drain();

        for (p = 0; p < PHASES; p++)
        begin
            send_idle = idle_mode_t'(p % 3);
            recv_idle = idle_mode_t'((p + 1) % 3);
            write_threshold((p == 4) ? THR_WIDTH'($urandom_range(1, 16))
                                     : THR_WIDTH'(phase_thr[p]));
            if (p == 1)
            begin
                // Display side goes quiet while the sender keeps offering requests.
                queue_random_phase(PHASE_ITEMS);
                @(posedge clk);
                recv_block = 1'b1;
                repeat (LONG_STALL) @(posedge clk);
                recv_block = 1'b0;
            end
            else if (p == 3)
            begin
                // Sender stops halfway until every outstanding result is back.
                queue_random_phase(PHASE_ITEMS / 2);
                wait_for_drain();
                @(posedge clk);
                queue_random_phase(PHASE_ITEMS / 2);
            end
            else
                queue_random_phase(PHASE_ITEMS);
            wait_for_drain();
        end

        $display("Checked %0d results from %0d samples under %0d threshold settings.",
                 results_checked, samples_sent, settings_used);
        $display("Count stepped up %0d and down %0d times; sample input stalled %0d cycles.",
                 steps_up, steps_down, input_stalls);
        if (error_count == 0)
            $display("hex_updown_display_mux_core_test: done, clean");
        else
            $display("hex_updown_display_mux_core_test: done, errors");
        $finish;
    end

endmodule
